@@ design/sfp_pkg.sv @@
// Shared types, constants and the CRC-8 step for the sample frame packer.
`timescale 1ns / 1ps

package sfp_pkg;

    localparam int FRAME_WORDS = 9;
    localparam int FRAME_LEN   = (FRAME_WORDS < 2) ? 2 : ((FRAME_WORDS > 15) ? 15 : FRAME_WORDS);
    localparam int WIDX_W      = 4;

    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] START_RST = 8'hFF;
    localparam logic [6:0] FRAG_RST  = 7'd20;
    localparam logic [6:0] FRAG_MIN  = 7'd1;
    localparam logic [6:0] FRAG_MAX  = 7'd64;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_START = 2'd0;
    localparam t_cfg_idx CFG_FRAG  = 2'd1;

    // byte slot within one word's burst
    typedef logic [2:0] t_pos;
    localparam t_pos POS_START = 3'd0;
    localparam t_pos POS_D0    = 3'd1;
    localparam t_pos POS_D1    = 3'd2;
    localparam t_pos POS_D2    = 3'd3;
    localparam t_pos POS_D3    = 3'd4;
    localparam t_pos POS_CRC   = 3'd5;

    typedef struct packed {
        logic [7:0] start_value;
        logic [6:0] frag_limit;
    } t_cfg;

    typedef struct packed {
        logic has_start;
        logic has_crc;
    } t_frame_flags;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b_in);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = b_in;
        for (int k = 0; k < 8; k++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

@@ design/sfp_in_if.sv @@
// Input word channel.
`timescale 1ns / 1ps

interface sfp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

@@ design/sfp_out_if.sv @@
// Output byte channel.
`timescale 1ns / 1ps

interface sfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       fragment_end;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, output out_byte, output fragment_end, output frame_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input fragment_end, input frame_end,
                    input run_last, output ready);
endinterface

@@ design/sfp_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps

interface sfp_cfg_if;
    import sfp_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_idx   index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/sfp_cfg_regs.sv @@
// Configuration registers: start byte and clamped fragment size.
`timescale 1ns / 1ps

module sfp_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sfp_cfg_if.sink       i_cfg,
    output sfp_pkg::t_cfg o_cfg
);
    import sfp_pkg::*;

    logic [7:0] r_start;
    logic [6:0] r_frag;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RST;
            r_frag  <= FRAG_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_START: r_start <= i_cfg.data;
                CFG_FRAG:  r_frag  <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.start_value = r_start;
        if (r_frag == 7'd0) begin
            o_cfg.frag_limit = FRAG_MIN;
        end else if (r_frag > FRAG_MAX) begin
            o_cfg.frag_limit = FRAG_MAX;
        end else begin
            o_cfg.frag_limit = r_frag;
        end
    end

endmodule

@@ design/sfp_frame_ctl.sv @@
// Word position within the frame; flags start and CRC bytes for each word.
`timescale 1ns / 1ps

module sfp_frame_ctl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    output sfp_pkg::t_frame_flags o_flags
);
    import sfp_pkg::*;

    logic [WIDX_W-1:0] r_widx;
    logic [WIDX_W-1:0] n_widx;
    logic              last_word;

    assign last_word = ({1'b0, r_widx} + (WIDX_W+1)'(1)) >= (WIDX_W+1)'(FRAME_LEN);

    assign o_flags.has_start = (r_widx == '0);
    assign o_flags.has_crc   = last_word;

    always_comb begin
        n_widx = r_widx;
        if (i_accept) begin
            n_widx = last_word ? '0 : r_widx + WIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
        end else begin
            r_widx <= n_widx;
        end
    end

endmodule

@@ design/sfp_byte_ser.sv @@
// Word register and byte serializer with running CRC and fragment fill.
`timescale 1ns / 1ps

module sfp_byte_ser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfp_pkg::t_cfg         i_cfg,
    input  sfp_pkg::t_frame_flags i_flags,
    sfp_in_if.sink                i_in,
    sfp_out_if.source             o_out
);
    import sfp_pkg::*;

    logic        r_busy;
    logic [31:0] r_word;
    t_pos        r_pos;
    t_pos        r_end;
    logic [7:0]  r_crc;
    logic [5:0]  r_fill;

    logic [7:0]  cur_byte;
    logic        is_crc;
    logic        is_start;
    logic [5:0]  fill_eff;
    logic        fend;
    logic        last;
    logic        take;
    logic        load;
    logic [7:0]  crc_base;

    always_comb begin
        case (r_pos)
            POS_START: cur_byte = i_cfg.start_value;
            POS_D0:    cur_byte = r_word[7:0];
            POS_D1:    cur_byte = r_word[15:8];
            POS_D2:    cur_byte = r_word[23:16];
            POS_D3:    cur_byte = r_word[31:24];
            default:   cur_byte = r_crc;
        endcase
    end

    assign is_crc   = (r_pos == POS_CRC);
    assign is_start = (r_pos == POS_START);
    assign fill_eff = is_start ? 6'd0 : r_fill;
    assign fend     = is_crc || (({1'b0, fill_eff} + 7'd1) >= i_cfg.frag_limit);
    assign last     = (r_pos == r_end);
    assign crc_base = is_start ? 8'd0 : r_crc;

    assign take        = r_busy && o_out.ready;
    assign i_in.ready  = !r_busy || (o_out.ready && last);
    assign load        = i_in.valid && i_in.ready;

    assign o_out.valid        = r_busy;
    assign o_out.out_byte     = cur_byte;
    assign o_out.fragment_end = fend;
    assign o_out.frame_end    = is_crc;
    assign o_out.run_last     = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_START;
            r_end  <= POS_D3;
            r_crc  <= 8'd0;
            r_fill <= 6'd0;
        end else begin
            if (take) begin
                r_fill <= fend ? 6'd0 : fill_eff + 6'd1;
                r_crc  <= is_crc ? 8'd0 : crc_byte(crc_base, cur_byte);
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + t_pos'(1);
                end
            end
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= i_flags.has_start ? POS_START : POS_D0;
                r_end  <= i_flags.has_crc ? POS_CRC : POS_D3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= i_in.data_word;
        end
    end

    a_crc_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_end |-> o_out.fragment_end && o_out.run_last)
        else $error("CRC beat without fragment or run end");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy)
        else $error("accepted word not held");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos <= r_end) && (r_end == POS_D3 || r_end == POS_CRC))
        else $error("byte slot out of range");

    a_no_early_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !last |-> !i_in.ready)
        else $error("word accepted before burst drained");

endmodule

@@ design/sample_frame_packer_crc8.sv @@
// Top level of the sample frame packer with CRC-8.
// The first byte of a word is offered in the cycle after the word beat.
// Each word yields 4 output bytes, 5 on the first and last word of a frame;
// the next word is taken in the cycle its predecessor's last byte leaves.
// The single byte serializer sets the rate at one byte per cycle while the receiver is ready.
// Reset (synchronous, active low) clears frame position, CRC and fragment fill.
`timescale 1ns / 1ps

module sample_frame_packer_crc8 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfp_cfg_if.sink   i_cfg,
    sfp_in_if.sink    i_in,
    sfp_out_if.source o_out
);
    import sfp_pkg::*;

    t_cfg         cfg;
    t_frame_flags flags;
    logic         accept;

    assign accept = i_in.valid && i_in.ready;

    sfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sfp_frame_ctl u_frame_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .o_flags  (flags)
    );

    sfp_byte_ser u_byte_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_flags (flags),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

@@ dv/sample_frame_packer_crc8_tb.sv @@
// Self-checking testbench for the sample frame packer: predicts bytes, flags and CRC per word.
`timescale 1ns / 1ps

module sample_frame_packer_crc8_tb;
    import sfp_pkg::*;

    localparam int          WORDS_PER_FRAME = (FRAME_WORDS < 2) ? 2 :
                                              ((FRAME_WORDS > 15) ? 15 : FRAME_WORDS);
    localparam logic [7:0]  CRC8_POLY_REFL  = 8'h8C;
    localparam logic [7:0]  START_AT_RESET  = 8'hFF;
    localparam logic [6:0]  FRAG_AT_RESET   = 7'd20;
    localparam t_cfg_idx    CFG_SPARE2      = 2'd2;
    localparam t_cfg_idx    CFG_SPARE3      = 2'd3;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          CYCLE_LIMIT     = 100000;

    typedef struct packed {
        logic [7:0] value;
        logic       frag_end;
        logic       frame_end;
        logic       run_last;
    } t_frame_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfp_cfg_if cfg_bus ();
    sfp_in_if  in_bus ();
    sfp_out_if out_bus ();

    sample_frame_packer_crc8 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [7:0] m_start;
    logic [6:0] m_frag_size;
    logic [3:0] m_word_idx;
    logic [7:0] m_crc;
    logic [5:0] m_fill;

    t_frame_byte pending_bytes[$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    bit          idle_on = 1'b0;
    int          rx_hold = 0;
    int          rx_gap = 0;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int frag_limit();
        if (m_frag_size == 7'd0) begin
            return 1;
        end
        if (m_frag_size > 7'd64) begin
            return 64;
        end
        return int'(m_frag_size);
    endfunction

    task automatic pack_word(input logic [31:0] w);
        logic [7:0]  seq[$];
        t_frame_byte b;
        bit          closes;
        if (m_word_idx == 4'd0) begin
            m_crc  = 8'h00;
            m_fill = 6'd0;
            seq.push_back(m_start);
        end
        for (int k = 0; k < 4; k++) begin
            seq.push_back(w[8*k +: 8]);
        end
        closes = (int'(m_word_idx) + 1 >= WORDS_PER_FRAME);
        foreach (seq[i]) begin
            b.value     = seq[i];
            b.frag_end  = (int'(m_fill) + 1 >= frag_limit());
            b.frame_end = 1'b0;
            b.run_last  = !closes && (i == seq.size() - 1);
            m_fill      = b.frag_end ? 6'd0 : m_fill + 6'd1;
            m_crc       = crc8_step(m_crc, seq[i]);
            pending_bytes.push_back(b);
        end
        if (closes) begin
            b = '{value: m_crc, frag_end: 1'b1, frame_end: 1'b1, run_last: 1'b1};
            pending_bytes.push_back(b);
            m_word_idx = 4'd0;
            m_crc      = 8'h00;
            m_fill     = 6'd0;
        end else begin
            m_word_idx = m_word_idx + 4'd1;
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_START: m_start = val;
            CFG_FRAG:  m_frag_size = val[6:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [31:0] w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_word <= w;
        do @(posedge i_clk); while (!in_bus.ready);
        pack_word(w);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_frame_defaults();
        logic [31:0] words[9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                  32'h3F80_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
                                  32'h7F7F_FFFF};
        foreach (words[i]) begin
            send_word(words[i]);
        end
        wait_drained();
    endtask

    task automatic test_register_edges();
        // every byte closes a fragment, start byte zero
        write_reg(CFG_START, 8'h00);
        write_reg(CFG_FRAG, 8'd1);
        send_word(32'hDEAD_BEEF);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0102_0408);
        wait_drained();
        // size zero behaves as one; spare indexes must not disturb anything
        write_reg(CFG_FRAG, 8'h00);
        write_reg(CFG_SPARE2, 8'h5A);
        write_reg(CFG_SPARE3, 8'hA5);
        send_word(32'hC0FF_EE00);
        send_word(32'h4049_0FDB);
        send_word(32'hBF80_0000);
        wait_drained();
        // oversize clamps to 64; top data bit is dropped by the register
        write_reg(CFG_FRAG, 8'hFF);
        write_reg(CFG_START, 8'hFF);
        send_word(32'h8000_0001);
        send_word(32'hFFFF_FFFF);
        wait_drained();
        write_reg(CFG_FRAG, 8'hC1);
        write_reg(CFG_START, 8'h80);
        send_word(32'h7FFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h55AA_55AA);
        send_word(32'h0F0F_F0F0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [7:0] frag_raw;
        idle_on = 1'b1;
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: frag_raw = 8'd1;
                1: frag_raw = 8'd64;
                2: frag_raw = 8'd38;
                3: frag_raw = 8'($urandom_range(0, 255));
                default: frag_raw = 8'($urandom_range(1, 64));
            endcase
            write_reg(CFG_FRAG, frag_raw);
            write_reg(CFG_START, 8'($urandom_range(0, 255)));
            repeat (16) send_word(pick_word());
        end
        wait_drained();
    endtask

    task automatic test_fill_and_stall();
        idle_on = 1'b1;
        write_reg(CFG_FRAG, 8'd7);
        rx_hold = 80;
        repeat (12) send_word(pick_word());
        wait_drained();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_reg(CFG_FRAG, 8'd20);
        write_reg(CFG_START, 8'h3C);
        repeat (20) send_word(pick_word());
        wait_drained();
    endtask

    // receiver ready: long hold, random short stalls, otherwise open
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_bus.ready <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                out_bus.ready <= 1'b0;
                rx_gap--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_bus.ready <= 1'b0;
                rx_gap = $urandom_range(0, 2);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : chk_beat
        t_frame_byte want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual byte %h fe %b fr %b rl %b",
                         $time, out_bus.out_byte, out_bus.fragment_end, out_bus.frame_end,
                         out_bus.run_last);
                mismatch_cnt++;
            end else begin
                want = pending_bytes.pop_front();
                if (out_bus.out_byte !== want.value) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.value,
                             out_bus.out_byte);
                    mismatch_cnt++;
                end
                if (out_bus.fragment_end !== want.frag_end) begin
                    $display("%0t: fragment_end expected %b actual %b", $time, want.frag_end,
                             out_bus.fragment_end);
                    mismatch_cnt++;
                end
                if (out_bus.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                             out_bus.frame_end);
                    mismatch_cnt++;
                end
                if (out_bus.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                             out_bus.run_last);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes outstanding", $time, pending_bytes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= CFG_START;
        cfg_bus.data     <= 8'h00;
        in_bus.valid     <= 1'b0;
        in_bus.data_word <= 32'h0;
        m_start     = START_AT_RESET;
        m_frag_size = FRAG_AT_RESET;
        m_word_idx  = 4'd0;
        m_crc       = 8'h00;
        m_fill      = 6'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_defaults();
        test_register_edges();
        test_random_phases();
        test_fill_and_stall();
        test_steady_stream();

        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
